// ----- rtl/dqsd_pkg.sv -----
// Package for the double-ended queue with search and delete.
// Holds opcode and status codes, field widths and the result record.
// No dependencies.
`timescale 1ns / 1ps

package dqsd_pkg;

	localparam int VALUE_W     = 32;
	localparam int OPCODE_W    = 3;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DELETE     = 3'd4,
		OP_SEARCH     = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] popped_value;
		logic                      found;
		status_t                   status;
		logic [COUNT_OUT_W-1:0]    entry_count;
	} res_t;

endpackage

// ----- rtl/deque_with_search_delete_core.sv -----
// Top level of the bounded double-ended queue with search and delete.
// Depends on dqsd_pkg, dqsd_ram and dqsd_seq.
//
// Channel   Direction  Transaction contents
// s_*       in         opcode [2:0], value [34:3] (signed), zero fill [39:35]
// m_*       out        popped_value [31:0], found [32], status [34:33], entry_count [39:35]
//
// A transaction is accepted only while the sequencer is idle: a push or a spare opcode
// goes straight to the result, a pop first reads its entry, and the result then waits
// for the output register. Search and delete walk the entries front first through one read
// port and one compare, one entry at a time; a delete then closes the gap entry by entry.
// The worst case, a miss or a delete over a full deque, is set by the single memory port;
// no new transaction is accepted before the current one has handed over its result.
// Reset clears the control registers, not the entry store, which needs no clearing pass.
// The result register lets the next transaction be accepted while a result is stalled.
`timescale 1ns / 1ps

module deque_with_search_delete_core import dqsd_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode, value, zero fill
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // popped_value, found, status, entry_count
);

	// Index width for the ring, count width able to hold CAPACITY itself.
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	opcode_t                   in_opcode;
	logic signed [VALUE_W-1:0] in_value;
	logic                      res_valid;
	logic                      res_take;
	res_t                      res;
	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic signed [VALUE_W-1:0] ram_wdata;
	logic [IW-1:0]             ram_raddr;
	logic signed [VALUE_W-1:0] ram_rdata;
	logic                      m_tvalid_q;
	logic [OUT_TDATA_W-1:0]    m_tdata_q;

	assign in_opcode = opcode_t'(s_tdata[OPCODE_W-1:0]);
	assign in_value  = s_tdata[OPCODE_W +: VALUE_W];

	// The sequencer hands over its result once the output register is free or draining.
	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	dqsd_seq #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.CW       (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (in_opcode),
		.in_value  (in_value),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	dqsd_ram #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register: valid is control state, the payload is loaded only on hand-over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			m_tdata_q <= {res.entry_count, res.status, res.found, res.popped_value};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/dqsd_ram.sv -----
// Entry store of the queue: one write port and one read port with registered read data.
// Depends on dqsd_pkg for the entry width.
`timescale 1ns / 1ps

module dqsd_ram import dqsd_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic signed [VALUE_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic signed [VALUE_W-1:0] rdata
);

	logic signed [VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/dqsd_seq.sv -----
// Sequencer of the queue: head pointer, count, the shared address unit and the
// shared equality compare, stepping scans and gap-closing shifts one entry at a time.
// Depends on dqsd_pkg and drives the dqsd_ram ports.
`timescale 1ns / 1ps

module dqsd_seq import dqsd_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int IW       = 4,
	parameter int CW       = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  opcode_t                   in_opcode,
	input  logic signed [VALUE_W-1:0] in_value,
	output logic                      res_valid,
	input  logic                      res_take,
	output res_t                      res,
	output logic                      ram_we,
	output logic [IW-1:0]             ram_waddr,
	output logic signed [VALUE_W-1:0] ram_wdata,
	output logic [IW-1:0]             ram_raddr,
	input  logic signed [VALUE_W-1:0] ram_rdata
);

	localparam int EXT_W = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;
	localparam logic [IW:0] CAP_X = (IW+1)'(CAPACITY);
	localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_SH_RD, S_SH_WR, S_POP, S_DONE
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	opcode_t                   op_q;
	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] popped_q;
	logic                      found_q;
	status_t                   status_q;

	logic          accept;
	logic [CW-1:0] lidx;
	logic [IW:0]   sum;
	logic [IW-1:0] phys;
	logic [IW-1:0] head_dec;
	logic [IW-1:0] head_inc;
	logic [CW-1:0] idx_inc;
	logic [CW-1:0] idx_inc2;
	logic [CW-1:0] count_dec;
	logic          match;
	logic [EXT_W-1:0] count_ext;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign idx_inc   = idx_q + 1'b1;
	assign idx_inc2  = idx_q + CW'(2);
	assign count_dec = count_q - 1'b1;
	assign head_dec  = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	// Logical position chosen by the current step.
	always_comb begin
		case (state_q)
			S_IDLE: begin
				if (in_opcode == OP_POP_BACK) begin
					lidx = count_dec;
				end else if (in_opcode == OP_POP_FRONT) begin
					lidx = '0;
				end else begin
					lidx = count_q;
				end
			end
			S_SH_RD: lidx = idx_inc;
			default: lidx = idx_q;
		endcase
	end

	// Shared address unit: ring position of a logical index.
	always_comb begin
		sum = {1'b0, head_q} + (IW+1)'(lidx);
		if (sum >= CAP_X) begin
			sum = sum - CAP_X;
		end
		phys = sum[IW-1:0];
	end

	// Shared compare unit.
	assign match = (ram_rdata == val_q);

	assign ram_raddr = phys;
	assign ram_we = (accept && count_q != CAP_C &&
		(in_opcode == OP_PUSH_FRONT || in_opcode == OP_PUSH_BACK)) ||
		(state_q == S_SH_WR);
	assign ram_waddr = (state_q == S_IDLE && in_opcode == OP_PUSH_FRONT) ? head_dec : phys;
	assign ram_wdata = (state_q == S_IDLE) ? in_value : ram_rdata;

	assign count_ext = EXT_W'(count_q);
	assign res.popped_value = popped_q;
	assign res.found        = found_q;
	assign res.status       = status_q;
	assign res.entry_count  = count_ext[COUNT_OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			op_q     <= OP_PUSH_FRONT;
			found_q  <= 1'b0;
			status_q <= ST_OK;
			popped_q <= '0;
			val_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= in_opcode;
						val_q    <= in_value;
						idx_q    <= '0;
						found_q  <= 1'b0;
						status_q <= ST_OK;
						popped_q <= '0;
						state_q  <= S_DONE;
						case (in_opcode)
							OP_PUSH_FRONT: begin
								if (count_q == CAP_C) begin
									status_q <= ST_FULL;
								end else begin
									head_q  <= head_dec;
									count_q <= count_q + 1'b1;
								end
							end
							OP_PUSH_BACK: begin
								if (count_q == CAP_C) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									state_q <= S_POP;
								end
							end
							OP_DELETE, OP_SEARCH: begin
								if (count_q != '0) begin
									state_q <= S_RD;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_POP: begin
					popped_q <= ram_rdata;
					count_q  <= count_dec;
					if (op_q == OP_POP_FRONT) begin
						head_q <= head_inc;
					end
					state_q <= S_DONE;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						if (op_q == OP_SEARCH) begin
							state_q <= S_DONE;
						end else if (idx_inc == count_q) begin
							count_q <= count_dec;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SH_RD;
						end
					end else if (idx_inc == count_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_inc;
						state_q <= S_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					idx_q <= idx_inc;
					if (idx_inc2 == count_q) begin
						count_q <= count_dec;
						state_q <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for deque_with_search_delete_core: a directed opening, then random
// fill, drain, search and mixed phases, each result checked against a behavioural deque model.
// Depends on dqsd_pkg and the core with its submodules.
`timescale 1ns / 1ps

module tb_top;
	import dqsd_pkg::*;

	localparam int CAPACITY = 16;

	// Opcodes 6 and 7 are spare: the block answers them as a no-operation.
	localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

	// A search or delete may inspect every entry and then close the gap; the bound below
	// allows about twice that work as margin.
	localparam int WORST_LATENCY = 4 * CAPACITY + 8;
	localparam int RANDOM_ITEMS  = 1430;
	// The slowest correct run is roughly 1450 transactions at their worst latency, plus
	// the random gaps on both sides and the long receiver hold-off; this is several
	// times that.
	localparam int LIMIT_CYCLES  = 600000;
	// The receiver holds off once HOLD_AT transactions have gone in, while the HOLD_LEN countdown runs.
	localparam int HOLD_AT       = 300;
	localparam int HOLD_LEN      = 400;
	// No random idling on either side while the accepted count lies in this window.
	localparam int QUIET_FROM    = 700;
	localparam int QUIET_TO      = 950;

	typedef struct {
		logic [OPCODE_W-1:0]       opcode;
		logic signed [VALUE_W-1:0] value;
		bit                        wait_drain; // sender holds until all results are in
	} deque_req_t;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_SEEK, MIX_ANY} mix_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;    // opcode, value, zero fill
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // popped_value, found, status, entry_count

	deque_req_t req_q[$];      // requests still to be offered
	res_t       result_q[$];   // predicted results, oldest first

	// Shadow copy of the deque, front at index 0.
	logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
	int                        shadow_fill;

	int  n_accepted;
	int  n_checked;
	int  errors;
	int  n_full_push;
	int  n_empty_pop;
	int  n_hits;
	int  hold_left;
	bit  hold_done;
	int  cycles;

	logic signed [VALUE_W-1:0] value_pool [8];

	deque_with_search_delete_core #(.CAPACITY(CAPACITY)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Applies one operation to the shadow deque and returns the result the block owes.
	function automatic res_t apply_deque_op(logic [OPCODE_W-1:0] op,
			logic signed [VALUE_W-1:0] v);
		res_t r;
		int   i;
		int   hit;
		r.popped_value = '0;
		r.found        = 1'b0;
		r.status       = ST_OK;
		hit            = -1;
		for (i = 0; i < shadow_fill; i++) begin
			if (hit < 0 && shadow_entries[i] == v)
				hit = i;
		end
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (shadow_fill >= CAPACITY) begin
					r.status = ST_FULL;
					n_full_push++;
				end else if (op == OP_PUSH_FRONT) begin
					for (i = shadow_fill; i > 0; i--)
						shadow_entries[i] = shadow_entries[i - 1];
					shadow_entries[0] = v;
					shadow_fill++;
				end else begin
					shadow_entries[shadow_fill] = v;
					shadow_fill++;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (shadow_fill == 0) begin
					r.status = ST_EMPTY;
					n_empty_pop++;
				end else if (op == OP_POP_FRONT) begin
					r.popped_value = shadow_entries[0];
					for (i = 0; i < shadow_fill - 1; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_fill--;
				end else begin
					r.popped_value = shadow_entries[shadow_fill - 1];
					shadow_fill--;
				end
			end
			OP_DELETE: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					n_hits++;
					for (i = hit; i < shadow_fill - 1; i++)
						shadow_entries[i] = shadow_entries[i + 1];
					shadow_fill--;
				end
			end
			OP_SEARCH: begin
				if (hit >= 0) begin
					r.found = 1'b1;
					n_hits++;
				end
			end
			default: begin
			end
		endcase
		r.entry_count = COUNT_OUT_W'(shadow_fill);
		return r;
	endfunction

	task automatic queue_req(logic [OPCODE_W-1:0] op, logic signed [VALUE_W-1:0] v,
			bit wait_drain = 1'b0);
		deque_req_t q;
		q.opcode     = op;
		q.value      = v;
		q.wait_drain = wait_drain;
		req_q.push_back(q);
	endtask

	// Values mostly come from a small pool so that searches and deletes hit, and
	// duplicates sit in the deque; the rest cover every bit of the field.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return value_pool[$urandom_range(7)];
		else if (r < 62)
			return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		else
			return $urandom;
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_op(mix_t mix);
		int r;
		r = $urandom_range(99);
		if (r == 99)
			return $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
		case (mix)
			MIX_FILL: begin
				if (r < 40) return OP_PUSH_FRONT;
				if (r < 75) return OP_PUSH_BACK;
				if (r < 82) return OP_POP_FRONT;
				if (r < 88) return OP_POP_BACK;
				if (r < 94) return OP_SEARCH;
				return OP_DELETE;
			end
			MIX_DRAIN: begin
				if (r < 35) return OP_POP_FRONT;
				if (r < 70) return OP_POP_BACK;
				if (r < 78) return OP_PUSH_FRONT;
				if (r < 85) return OP_PUSH_BACK;
				if (r < 92) return OP_DELETE;
				return OP_SEARCH;
			end
			MIX_SEEK: begin
				if (r < 20) return OP_PUSH_FRONT;
				if (r < 40) return OP_PUSH_BACK;
				if (r < 50) return OP_POP_FRONT;
				if (r < 55) return OP_POP_BACK;
				if (r < 75) return OP_DELETE;
				return OP_SEARCH;
			end
			default: begin
				return OPCODE_W'(r % 6);
			end
		endcase
	endfunction

	// Stimulus, end of run and the final verdict.
	initial begin
		int   made;
		int   seg_len;
		int   k;
		mix_t mix;

		value_pool[0] = 32'sd0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh7FFF_FFFF;
		value_pool[3] = 32'sh8000_0000;
		for (k = 4; k < 8; k++)
			value_pool[k] = $urandom;

		// Directed opening: every operation on an empty deque, the spare opcodes, the
		// extreme values, a duplicate, hits and misses, and draining back to empty.
		queue_req(OP_POP_FRONT, 32'sd0);
		queue_req(OP_POP_BACK, 32'sd0);
		queue_req(OP_DELETE, 32'sd5);
		queue_req(OP_SEARCH, 32'sd5);
		queue_req(OP_SPARE_6, 32'sh7FFF_FFFF);
		queue_req(OP_SPARE_7, 32'sh8000_0000);
		queue_req(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
		queue_req(OP_PUSH_BACK, 32'sh8000_0000);
		queue_req(OP_PUSH_FRONT, 32'sd0);
		queue_req(OP_PUSH_BACK, -32'sd1);
		queue_req(OP_PUSH_BACK, 32'sd0);
		queue_req(OP_SEARCH, 32'sh8000_0000);
		queue_req(OP_SEARCH, 32'sd12345);
		queue_req(OP_DELETE, 32'sd0);
		queue_req(OP_DELETE, 32'sd777);
		queue_req(OP_SEARCH, 32'sd0);
		queue_req(OP_POP_FRONT, 32'sd0);
		queue_req(OP_POP_BACK, 32'sd0);
		queue_req(OP_POP_BACK, 32'sd0);
		queue_req(OP_POP_FRONT, 32'sd0);
		queue_req(OP_POP_FRONT, 32'sd0);

		// Random part in segments of one character each: filling phases reach the full
		// deque, draining phases the empty one, seeking phases exercise search and delete.
		made = 0;
		while (made < RANDOM_ITEMS) begin
			mix     = mix_t'($urandom_range(3));
			seg_len = $urandom_range(20, 60);
			for (k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
				queue_req(pick_op(mix), pick_value(),
					(made == 0) || ($urandom_range(149) == 0));
				made++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (WORST_LATENCY) @(posedge clk);

		if (result_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, result_q.size());
			errors++;
		end
		$display("Summary: %0d transactions in, %0d results checked.", n_accepted, n_checked);
		$display("Summary: %0d pushes on full, %0d pops on empty, %0d search/delete hits.",
			n_full_push, n_empty_pop, n_hits);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Driver. The prediction is taken at the edge where the transaction is accepted;
	// its result can only come back at a later edge, so the result queue never
	// runs dry under the monitor because of ordering within one edge.
	always @(posedge clk or negedge arst_n) begin : drive_proc
		logic       took;
		logic       quiet;
		deque_req_t nxt;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			n_accepted <= 0;
		end else begin
			took  = s_tvalid && s_tready;
			quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);
			if (took) begin
				result_q.push_back(apply_deque_op(s_tdata[OPCODE_W-1:0],
					s_tdata[OPCODE_W+VALUE_W-1:OPCODE_W]));
				n_accepted <= n_accepted + 1;
			end
			if (s_tvalid && !s_tready) begin
				// Offer stays up unchanged until the block takes it.
			end else if (req_q.size() != 0 && (quiet || $urandom_range(99) >= 8) &&
					(!req_q[0].wait_drain || (!took && result_q.size() == 0))) begin
				nxt = req_q.pop_front();
				s_tdata  <= {{(IN_TDATA_W - OPCODE_W - VALUE_W){1'b0}}, nxt.value, nxt.opcode};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// The long receiver hold-off, counted here so that the sender keeps offering
	// and the block fills its result register and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: each accepted result is unpacked and compared with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : watch_proc
		res_t got;
		res_t want;
		logic quiet;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			n_checked <= 0;
		end else begin
			quiet = (n_accepted >= QUIET_FROM) && (n_accepted < QUIET_TO);
			if (m_tvalid && m_tready) begin
				got.popped_value = m_tdata[VALUE_W-1:0];
				got.found        = m_tdata[VALUE_W];
				got.status       = status_t'(m_tdata[VALUE_W+STATUS_W:VALUE_W+1]);
				got.entry_count  = m_tdata[OUT_TDATA_W-1:VALUE_W+STATUS_W+1];
				n_checked <= n_checked + 1;
				if (result_q.size() == 0) begin
					$display("%0t: result with nothing expected, tdata %h", $time, m_tdata);
					errors++;
				end else begin
					want = result_q.pop_front();
					if (got.popped_value !== want.popped_value) begin
						$display("%0t: popped_value expected %0d actual %0d", $time,
							want.popped_value, got.popped_value);
						errors++;
					end
					if (got.found !== want.found) begin
						$display("%0t: found expected %0b actual %0b", $time,
							want.found, got.found);
						errors++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
						errors++;
					end
					if (got.entry_count !== want.entry_count) begin
						$display("%0t: entry_count expected %0d actual %0d", $time,
							want.entry_count, got.entry_count);
						errors++;
					end
				end
			end
			m_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 8);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: run stopped by the cycle limit", $time);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		cycles      = 0;
		errors      = 0;
		n_full_push = 0;
		n_empty_pop = 0;
		n_hits      = 0;
		shadow_fill = 0;
		for (int i = 0; i < CAPACITY; i++)
			shadow_entries[i] = '0;
	end

endmodule

// ----- files.f -----
rtl/dqsd_pkg.sv
rtl/dqsd_ram.sv
rtl/dqsd_seq.sv
rtl/deque_with_search_delete_core.sv
verif/tb_top.sv
